// File: hw/rtl/rpch_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpch_pkg: shared constants for the radial pair-count histogram
// Sizes, field widths, transaction kinds and register indexes.
// ----------------------------------------------------------------------------
package rpch_pkg;

  localparam int MAX_BINS   = 32;
  localparam int MAX_POINTS = 1024;
  localparam int COORD_BITS = 24;

  localparam int BIN_IW = $clog2(MAX_BINS);
  localparam int NB_W   = $clog2(MAX_BINS + 1);
  localparam int PT_AW  = $clog2(MAX_POINTS);
  localparam int PT_CW  = PT_AW + 1;
  localparam int QIDX_W = 11;
  localparam int SCAN_W = ((PT_CW > QIDX_W) ? PT_CW : QIDX_W) + 1;

  localparam int POS_W  = 24;
  localparam int OFS_W  = 24;
  localparam int Q_W    = OFS_W + 1;
  localparam int D_W    = Q_W + 1;
  localparam int SQ_W   = 2 * D_W;
  localparam int DIST_W = 54;
  localparam int ZL_W   = 25;
  localparam int CNT_W  = 48;
  localparam int NBR_W  = 3 * COORD_BITS;
  localparam int CFG_IW = 3;

  localparam logic [QIDX_W-1:0] QIDX_MAX = '1;
  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

  typedef logic [1:0]        kind_t;
  typedef logic [CFG_IW-1:0] cfg_idx_t;

  localparam kind_t KIND_EDGE  = 2'd0;
  localparam kind_t KIND_POINT = 2'd1;
  localparam kind_t KIND_QUERY = 2'd2;
  localparam kind_t KIND_FLUSH = 2'd3;

  localparam cfg_idx_t CFG_NUM_BINS = 3'd0;
  localparam cfg_idx_t CFG_SAME_SET = 3'd1;
  localparam cfg_idx_t CFG_Z_LIMIT  = 3'd2;
  localparam cfg_idx_t CFG_MIN_DIST = 3'd3;
  localparam cfg_idx_t CFG_MAX_DIST = 3'd4;
  localparam cfg_idx_t CFG_OFFSET_X = 3'd5;
  localparam cfg_idx_t CFG_OFFSET_Y = 3'd6;
  localparam cfg_idx_t CFG_OFFSET_Z = 3'd7;

  // Clamp the bin register into 1 .. MAX_BINS.
  function automatic logic [NB_W-1:0] bins_in_use(input logic [5:0] nb);
    logic [NB_W-1:0] res;
    if (nb == 6'd0) begin
      res = NB_W'(1);
    end else if (int'(nb) > MAX_BINS) begin
      res = NB_W'(MAX_BINS);
    end else begin
      res = NB_W'(nb);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/rpch_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpch_ram: generic single-write, single-read RAM
// Registered read; read returns old data on a collision.
// ----------------------------------------------------------------------------
module rpch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/radial_pair_count_histogram_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// radial_pair_count_histogram_core: pair-count histogram over squared radius
// Loads bin edges and a z-sorted neighbor set, scans neighbors per query and
// accumulates saturating bin counts; a flush streams the counts out.
// ----------------------------------------------------------------------------
// Usage: edge and neighbor loads are accepted back to back while idle. A
// query scans the neighbor memory one point per cycle (one read port), first
// skipping points below the z window (normal mode) or starting after the
// query's own index (same-set mode), and stops at the first point with
// dz >= z_limit or at the end of the set; it then drains a seven-stage
// pipeline (memory read, difference, square, sum, edge compare, bin select,
// count update). A flush reads and reports the bins in turn, waits out any
// output stall, and clears all counts. The input is stalled while a query or
// flush is in progress; a pending output transaction does not block new
// input. Counts live in a 32-entry RAM with per-bin valid bits (cleared at
// reset and at flush end); back-to-back updates of one bin are forwarded.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module radial_pair_count_histogram_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rpch_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [rpch_pkg::DIST_W-1:0]   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_kind,
  input  logic signed [rpch_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [rpch_pkg::POS_W-1:0] in_pos_y,
  input  logic signed [rpch_pkg::POS_W-1:0] in_pos_z,
  input  logic                          in_first_point,
  input  logic [4:0]                    in_edge_index,
  input  logic [rpch_pkg::DIST_W-1:0]   in_edge_value_sq,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [4:0]                    out_bin_number,
  output logic [rpch_pkg::CNT_W-1:0]    out_pair_count,
  output logic                          out_last_bin
);
  import rpch_pkg::*;

  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_SCAN     = 2'd1;
  localparam logic [1:0] ST_FLUSH_RD = 2'd2;
  localparam logic [1:0] ST_FLUSH_WT = 2'd3;

  // Configuration registers
  logic [5:0]              num_bins_r;
  logic                    same_set_r;
  logic [ZL_W-1:0]         z_limit_r;
  logic [DIST_W-1:0]       min_dist_r;
  logic [DIST_W-1:0]       max_dist_r;
  logic signed [OFS_W-1:0] offset_x_r, offset_y_r, offset_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_bins_r <= 6'd32;
      same_set_r <= 1'b0;
      z_limit_r  <= '1;
      min_dist_r <= '0;
      max_dist_r <= '1;
      offset_x_r <= '0;
      offset_y_r <= '0;
      offset_z_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NUM_BINS: num_bins_r <= cfg_wdata[5:0];
        CFG_SAME_SET: same_set_r <= cfg_wdata[0];
        CFG_Z_LIMIT:  z_limit_r  <= cfg_wdata[ZL_W-1:0];
        CFG_MIN_DIST: min_dist_r <= cfg_wdata;
        CFG_MAX_DIST: max_dist_r <= cfg_wdata;
        CFG_OFFSET_X: offset_x_r <= signed'(cfg_wdata[OFS_W-1:0]);
        CFG_OFFSET_Y: offset_y_r <= signed'(cfg_wdata[OFS_W-1:0]);
        CFG_OFFSET_Z: offset_z_r <= signed'(cfg_wdata[OFS_W-1:0]);
        default: ;
      endcase
    end
  end

  logic [NB_W-1:0] nb_use;
  assign nb_use = bins_in_use(num_bins_r);

  // Control state
  logic [1:0]        state_r, state_nxt;
  logic [PT_CW-1:0]  pt_total_r, pt_total_nxt;
  logic [QIDX_W-1:0] qidx_r, qidx_nxt;
  logic [SCAN_W-1:0] scan_j_r, scan_j_nxt;
  logic              scan_act_r, scan_act_nxt;
  logic              skip_r, skip_nxt;
  logic [BIN_IW-1:0] fl_k_r, fl_k_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              d_vld_r, e_vld_r, f_vld_r, g_vld_r, h_vld_r, i_vld_r;
  logic              w_vld_r;
  logic [MAX_BINS-1:0] cnt_ok_r;

  logic pipe_busy;
  logic in_acc;
  assign pipe_busy = d_vld_r | e_vld_r | f_vld_r | g_vld_r | h_vld_r | i_vld_r;
  assign in_stall  = (state_r != ST_IDLE) || pipe_busy;
  assign in_acc    = in_valid && !in_stall;

  // Query point with wrap offsets applied
  logic signed [Q_W-1:0] qx_r, qy_r, qz_r;

  // Edge table: every entry but the last feeds its own comparator
  logic [DIST_W-1:0] edge_r [MAX_BINS];

  always_ff @(posedge clk) begin
    if (in_acc && in_kind == KIND_EDGE && int'(in_edge_index) < MAX_BINS) begin
      edge_r[in_edge_index[BIN_IW-1:0]] <= in_edge_value_sq;
    end
    if (in_acc && in_kind == KIND_QUERY) begin
      qx_r <= Q_W'(signed'(in_pos_x[COORD_BITS-1:0])) + Q_W'(offset_x_r);
      qy_r <= Q_W'(signed'(in_pos_y[COORD_BITS-1:0])) + Q_W'(offset_y_r);
      qz_r <= Q_W'(signed'(in_pos_z[COORD_BITS-1:0])) + Q_W'(offset_z_r);
    end
  end

  // Neighbor memory: {z, y, x}
  logic [PT_CW-1:0]  ld_base;
  logic              nbr_we;
  logic              nbr_re;
  logic [NBR_W-1:0]  nbr_rdata;
  assign ld_base = in_first_point ? '0 : pt_total_r;
  assign nbr_we  = in_acc && in_kind == KIND_POINT && int'(ld_base) < MAX_POINTS;
  assign nbr_re  = scan_act_r && (scan_j_r < SCAN_W'(pt_total_r));

  rpch_ram #(.WIDTH(NBR_W), .DEPTH(MAX_POINTS)) u_nbr_ram (
    .clk   (clk),
    .we    (nbr_we),
    .waddr (ld_base[PT_AW-1:0]),
    .wdata ({in_pos_z[COORD_BITS-1:0], in_pos_y[COORD_BITS-1:0],
             in_pos_x[COORD_BITS-1:0]}),
    .re    (nbr_re),
    .raddr (scan_j_r[PT_AW-1:0]),
    .rdata (nbr_rdata)
  );

  // D stage: differences and z-window tests on the returned point
  logic signed [COORD_BITS-1:0] nb_x, nb_y, nb_z;
  logic signed [D_W-1:0] dx, dy, dz, zl_s, neg_zl;
  logic skip_now, stop_now, d_pass;

  assign nb_x   = signed'(nbr_rdata[COORD_BITS-1:0]);
  assign nb_y   = signed'(nbr_rdata[2*COORD_BITS-1:COORD_BITS]);
  assign nb_z   = signed'(nbr_rdata[3*COORD_BITS-1:2*COORD_BITS]);
  assign dx     = D_W'(nb_x) - D_W'(qx_r);
  assign dy     = D_W'(nb_y) - D_W'(qy_r);
  assign dz     = D_W'(nb_z) - D_W'(qz_r);
  assign zl_s   = signed'(D_W'(z_limit_r));
  assign neg_zl = -zl_s;

  assign skip_now = d_vld_r && skip_r && (dz <= neg_zl);
  assign stop_now = d_vld_r && !skip_now && (dz >= zl_s);
  assign d_pass   = d_vld_r && !skip_now && !stop_now;

  // E/F/G stages: square and sum
  logic signed [D_W-1:0]  e_dx_r, e_dy_r, e_dz_r;
  logic signed [SQ_W-1:0] sqx, sqy, sqz;
  logic [SQ_W-1:0]        f_sqx_r, f_sqy_r, f_sqz_r;
  logic [DIST_W-1:0]      g_r2_r;

  assign sqx = e_dx_r * e_dx_r;
  assign sqy = e_dy_r * e_dy_r;
  assign sqz = e_dz_r * e_dz_r;

  // G stage: range check and edge comparisons in parallel
  logic                in_range;
  logic [MAX_BINS-1:0] hit;
  logic [MAX_BINS-1:0] h_hit_r;

  assign in_range = (g_r2_r < max_dist_r) && (g_r2_r >= min_dist_r);

  always_comb begin
    hit = '0;
    for (int k = 1; k < MAX_BINS; k++) begin
      hit[k] = in_range && (NB_W'(k) < nb_use) && (g_r2_r >= edge_r[k-1]);
    end
  end

  // H stage: highest matching bin, issue count read
  logic [BIN_IW-1:0] enc_bin;
  logic              enc_any;

  always_comb begin
    enc_bin = '0;
    enc_any = 1'b0;
    for (int k = 1; k < MAX_BINS; k++) begin
      if (h_hit_r[k]) begin
        enc_bin = BIN_IW'(k);
        enc_any = 1'b1;
      end
    end
  end

  logic [BIN_IW-1:0] i_bin_r, w_bin_r;
  logic [CNT_W-1:0]  w_val_r;
  logic [CNT_W-1:0]  cnt_rdata, cnt_cur, cnt_new;
  logic              cnt_re;
  logic [BIN_IW-1:0] cnt_raddr;

  assign cnt_re    = (state_r == ST_FLUSH_RD) || (h_vld_r && enc_any);
  assign cnt_raddr = (state_r == ST_FLUSH_RD) ? fl_k_r : enc_bin;

  // I stage: forward the previous cycle's write, else memory or cleared zero
  always_comb begin
    if (w_vld_r && w_bin_r == i_bin_r) begin
      cnt_cur = w_val_r;
    end else if (cnt_ok_r[i_bin_r]) begin
      cnt_cur = cnt_rdata;
    end else begin
      cnt_cur = '0;
    end
    cnt_new = (cnt_cur == CNT_MAX) ? cnt_cur : cnt_cur + CNT_W'(1);
  end

  rpch_ram #(.WIDTH(CNT_W), .DEPTH(MAX_BINS)) u_cnt_ram (
    .clk   (clk),
    .we    (i_vld_r),
    .waddr (i_bin_r),
    .wdata (cnt_new),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  // Datapath registers (no reset)
  always_ff @(posedge clk) begin
    e_dx_r  <= dx;
    e_dy_r  <= dy;
    e_dz_r  <= dz;
    f_sqx_r <= unsigned'(sqx);
    f_sqy_r <= unsigned'(sqy);
    f_sqz_r <= unsigned'(sqz);
    g_r2_r  <= DIST_W'(f_sqx_r) + DIST_W'(f_sqy_r) + DIST_W'(f_sqz_r);
    h_hit_r <= hit;
    i_bin_r <= enc_bin;
    w_bin_r <= i_bin_r;
    w_val_r <= cnt_new;
  end

  // Flush output capture
  logic fl_last, out_free;
  assign fl_last  = (NB_W'(fl_k_r) + NB_W'(1)) == nb_use;
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (state_r == ST_FLUSH_WT && out_free) begin
      out_bin_number <= 5'(fl_k_r);
      out_pair_count <= cnt_ok_r[fl_k_r] ? cnt_rdata : '0;
      out_last_bin   <= fl_last;
    end
  end
  assign out_valid = out_valid_r;

  // Control next state
  always_comb begin
    state_nxt     = state_r;
    pt_total_nxt  = pt_total_r;
    qidx_nxt      = qidx_r;
    scan_j_nxt    = scan_j_r;
    scan_act_nxt  = scan_act_r;
    skip_nxt      = skip_r;
    fl_k_nxt      = fl_k_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (in_acc && in_kind == KIND_POINT) begin
      pt_total_nxt = nbr_we ? ld_base + PT_CW'(1) : ld_base;
      if (in_first_point) begin
        qidx_nxt = '0;
      end
    end

    if (in_acc && in_kind == KIND_QUERY) begin
      state_nxt    = ST_SCAN;
      scan_act_nxt = 1'b1;
      skip_nxt     = !same_set_r;
      scan_j_nxt   = same_set_r ? SCAN_W'(qidx_r) + SCAN_W'(1) : '0;
      if (qidx_r != QIDX_MAX) begin
        qidx_nxt = qidx_r + QIDX_W'(1);
      end
    end

    if (in_acc && in_kind == KIND_FLUSH) begin
      state_nxt = ST_FLUSH_RD;
      fl_k_nxt  = '0;
    end

    if (state_r == ST_SCAN) begin
      if (nbr_re) begin
        scan_j_nxt = scan_j_r + SCAN_W'(1);
      end else begin
        scan_act_nxt = 1'b0;
      end
      if (stop_now) begin
        scan_act_nxt = 1'b0;
      end
      if (d_vld_r && !skip_now) begin
        skip_nxt = 1'b0;
      end
      if (!scan_act_r) begin
        state_nxt = ST_IDLE;
      end
    end

    if (state_r == ST_FLUSH_RD) begin
      state_nxt = ST_FLUSH_WT;
    end

    if (state_r == ST_FLUSH_WT && out_free) begin
      out_valid_nxt = 1'b1;
      if (fl_last) begin
        state_nxt = ST_IDLE;
      end else begin
        fl_k_nxt  = fl_k_r + BIN_IW'(1);
        state_nxt = ST_FLUSH_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pt_total_r  <= '0;
      qidx_r      <= '0;
      scan_j_r    <= '0;
      scan_act_r  <= 1'b0;
      skip_r      <= 1'b0;
      fl_k_r      <= '0;
      out_valid_r <= 1'b0;
      d_vld_r     <= 1'b0;
      e_vld_r     <= 1'b0;
      f_vld_r     <= 1'b0;
      g_vld_r     <= 1'b0;
      h_vld_r     <= 1'b0;
      i_vld_r     <= 1'b0;
      w_vld_r     <= 1'b0;
      cnt_ok_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      pt_total_r  <= pt_total_nxt;
      qidx_r      <= qidx_nxt;
      scan_j_r    <= scan_j_nxt;
      scan_act_r  <= scan_act_nxt;
      skip_r      <= skip_nxt;
      fl_k_r      <= fl_k_nxt;
      out_valid_r <= out_valid_nxt;
      // Drop the read in flight behind a stopping point
      d_vld_r     <= nbr_re && !stop_now;
      e_vld_r     <= d_pass;
      f_vld_r     <= e_vld_r;
      g_vld_r     <= f_vld_r;
      h_vld_r     <= g_vld_r;
      i_vld_r     <= h_vld_r && enc_any;
      w_vld_r     <= i_vld_r;
      if (i_vld_r) begin
        cnt_ok_r[i_bin_r] <= 1'b1;
      end
      if (state_r == ST_FLUSH_WT && out_free && fl_last) begin
        cnt_ok_r <= '0;
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/rpch_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpch_checker: port-level checks for the pair-count histogram core
// Flush sequencing, bin order and output holding.
// ----------------------------------------------------------------------------
module rpch_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic [1:0]                 in_kind,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [4:0]                 out_bin_number,
  input logic [rpch_pkg::CNT_W-1:0] out_pair_count,
  input logic                       out_last_bin
);
  import rpch_pkg::*;

  logic [4:0] exp_bin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_bin_r <= '0;
    end else if (out_valid && !out_stall) begin
      exp_bin_r <= out_last_bin ? 5'd0 : out_bin_number + 5'd1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_bin_number)
      && $stable(out_pair_count) && $stable(out_last_bin))
    else $error("stalled output transaction changed");

  a_bin_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_bin_number == exp_bin_r)
    else $error("flush bins out of order");

  a_bin0_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bin_number == 5'd0 |-> out_pair_count == '0)
    else $error("bin 0 reported a nonzero count");

  a_flush_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_kind == KIND_FLUSH |=> in_stall)
    else $error("input taken right after a flush transaction");

endmodule

bind radial_pair_count_histogram_core rpch_checker u_rpch_checker (.*);
`default_nettype wire

// File: sim/radial_pair_count_histogram_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_pair_count_histogram_core_tb: self-checking bench for the pair-count core
// Loads edges and neighbor sets, runs queries under several register settings
// and checks every flushed bin count against an in-bench histogram predictor.
// ----------------------------------------------------------------------------
module radial_pair_count_histogram_core_tb;
  import rpch_pkg::*;

  localparam logic [53:0] M54 = {54{1'b1}};
  localparam int WATCHDOG = 200000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [23:0] px, py, pz;
    logic        first;
    logic [4:0]  eidx;
    logic [53:0] eval;
  } txn_t;

  typedef struct packed {
    logic [4:0]  bin;
    logic [47:0] cnt;
    logic        last;
  } bin_rpt_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [DIST_W-1:0] cfg_wdata;
  logic in_valid, in_stall;
  logic [1:0] in_kind;
  logic signed [POS_W-1:0] in_pos_x, in_pos_y, in_pos_z;
  logic in_first_point;
  logic [4:0] in_edge_index;
  logic [DIST_W-1:0] in_edge_value_sq;
  logic out_valid, out_stall;
  logic [4:0] out_bin_number;
  logic [CNT_W-1:0] out_pair_count;
  logic out_last_bin;

  radial_pair_count_histogram_core i_dut (.*);

  // Predictor state: edges, neighbor store, counts and register copies.
  logic [53:0] edge_sq [MAX_BINS];
  logic signed [23:0] nbr_x [MAX_POINTS], nbr_y [MAX_POINTS], nbr_z [MAX_POINTS];
  int unsigned pt_total, q_idx;
  logic [47:0] hist [MAX_BINS];
  logic [5:0]  r_bins;
  logic        r_same;
  logic [24:0] r_zlim;
  logic [53:0] r_min, r_max;
  logic signed [23:0] r_ox, r_oy, r_oz;

  bin_rpt_t pending_bins [$];
  txn_t     send_q [$];
  // Directed table, and the results typed in for the flush after reset
  txn_t     dir_tab [$];
  bin_rpt_t fixed_tab [$];
  int errors = 0;
  int idle_cycles = 0;
  bit edges_loaded = 0;
  bit long_hold = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned active_bins();
    if (r_bins == 0) return 1;
    if (r_bins > MAX_BINS) return MAX_BINS;
    return r_bins;
  endfunction

  // Scan the stored neighbors for one query and bump the matching bins.
  task automatic count_pairs(input logic signed [23:0] x, y, z);
    longint qx, qy, qz, dx, dy, dz, zl;
    longint unsigned r2;
    int unsigned j, nb;
    qx = longint'(x) + r_ox; qy = longint'(y) + r_oy; qz = longint'(z) + r_oz;
    zl = longint'(r_zlim);
    nb = active_bins();
    j = 0;
    if (r_same) begin
      j = q_idx + 1;
    end else begin
      while (j < pt_total && longint'(nbr_z[j]) - qz <= -zl) j++;
    end
    for (; j < pt_total && j < MAX_POINTS; j++) begin
      dx = longint'(nbr_x[j]) - qx;
      dy = longint'(nbr_y[j]) - qy;
      dz = longint'(nbr_z[j]) - qz;
      if (dz >= zl) break;
      r2 = dx * dx + dy * dy + dz * dz;
      if (r2 >= r_max || r2 < r_min) continue;
      for (int k = nb - 1; k >= 1; k--) begin
        if (r2 >= edge_sq[k-1]) begin
          if (hist[k] != {48{1'b1}}) hist[k]++;
          break;
        end
      end
    end
    if (q_idx < 2047) q_idx++;
  endtask

  task automatic predict(input txn_t t);
    int unsigned nb;
    bin_rpt_t r;
    case (t.kind)
      KIND_EDGE: edge_sq[t.eidx] = t.eval;
      KIND_POINT: begin
        if (t.first) begin
          pt_total = 0; q_idx = 0;
        end
        if (pt_total < MAX_POINTS) begin
          nbr_x[pt_total] = t.px; nbr_y[pt_total] = t.py; nbr_z[pt_total] = t.pz;
          pt_total++;
        end
      end
      KIND_QUERY: count_pairs(t.px, t.py, t.pz);
      default: begin
        nb = active_bins();
        for (int k = 0; k < nb; k++) begin
          r.bin = k[4:0]; r.cnt = hist[k]; r.last = (k + 1 == nb);
          pending_bins.push_back(r);
        end
        for (int k = 0; k < MAX_BINS; k++) hist[k] = '0;
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got, exp);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
    errors++;
  endtask

  // Wait out every outstanding count report, then let the core settle.
  task automatic drain();
    while (send_q.size() != 0 || pending_bins.size() != 0) @(posedge clk);
    repeat (1100) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [53:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      CFG_NUM_BINS: r_bins = val[5:0];
      CFG_SAME_SET: r_same = val[0];
      CFG_Z_LIMIT:  r_zlim = val[24:0];
      CFG_MIN_DIST: r_min = val;
      CFG_MAX_DIST: r_max = val;
      CFG_OFFSET_X: r_ox = val[23:0];
      CFG_OFFSET_Y: r_oy = val[23:0];
      default:      r_oz = val[23:0];
    endcase
  endtask

  function automatic txn_t mk(input logic [1:0] k, input logic [23:0] x, y, z,
                              input logic f, input logic [4:0] ei,
                              input logic [53:0] ev);
    txn_t t;
    t.kind = k; t.px = x; t.py = y; t.pz = z; t.first = f; t.eidx = ei; t.eval = ev;
    return t;
  endfunction

  function automatic logic [53:0] rnd54();
    return {$urandom(), $urandom()};
  endfunction

  // Sender: drain send_q in bursts with random gaps; never drop valid mid-item.
  initial begin
    in_valid = 0; in_kind = 0; in_pos_x = 0; in_pos_y = 0; in_pos_z = 0;
    in_first_point = 0; in_edge_index = 0; in_edge_value_sq = 0;
    @(posedge rst_n);
    forever begin
      int burst, gap;
      burst = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      while (burst > 0) begin
        if (send_q.size() == 0) begin
          in_valid <= 0;
          @(posedge clk);
        end else begin
          in_valid <= 1;
          in_kind <= send_q[0].kind;
          in_pos_x <= send_q[0].px; in_pos_y <= send_q[0].py; in_pos_z <= send_q[0].pz;
          in_first_point <= send_q[0].first;
          in_edge_index <= send_q[0].eidx; in_edge_value_sq <= send_q[0].eval;
          @(posedge clk);
          while (in_stall) @(posedge clk);
          predict(send_q.pop_front());
          burst--;
        end
      end
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Receiver stall pattern with one long hold-off to back the core up.
  initial begin
    int hold;
    out_stall = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1;
        for (hold = 0; hold < 400; hold++) @(posedge clk);
        long_hold = 0;
      end
      case ($urandom_range(0, 3))
        0: out_stall <= 1;
        1: out_stall <= $urandom_range(0, 1);
        default: out_stall <= 0;
      endcase
    end
  end

  // Result checker and idle watchdog.
  always @(posedge clk) begin
    bin_rpt_t e;
    bin_rpt_t f;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG);
        $display("FAIL radial_pair_count_histogram_core");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (pending_bins.size() == 0) begin
          report_mismatch("unexpected result bin", out_bin_number, 0);
        end else begin
          e = pending_bins.pop_front();
          if (out_bin_number !== e.bin) report_mismatch("bin_number", out_bin_number, e.bin);
          if (out_pair_count !== e.cnt) report_mismatch("pair_count", out_pair_count, e.cnt);
          if (out_last_bin !== e.last) report_mismatch("last_bin", out_last_bin, e.last);
        end
        // Rows with a typed-in result are checked against it as well
        if (fixed_tab.size() != 0) begin
          f = fixed_tab.pop_front();
          if ({out_bin_number, out_pair_count, out_last_bin} !== f)
            report_mismatch("fixed row", {out_bin_number, out_pair_count, out_last_bin}, f);
        end
      end
    end
  end

  // Push a neighbor set sorted by z, coordinates kept near a small cluster unless wild.
  task automatic load_set(input int n, input int spread, input bit wild);
    int z;
    logic [23:0] x, y;
    z = wild ? -8388608 : $urandom_range(0, 2 * spread) - spread;
    for (int i = 0; i < n; i++) begin
      x = wild ? $urandom() : $urandom_range(0, 2 * spread) - spread;
      y = wild ? $urandom() : $urandom_range(0, 2 * spread) - spread;
      send_q.push_back(mk(KIND_POINT, x, y, z[23:0], i == 0, 0, 0));
      z += wild ? $urandom_range(0, 16777215 / (n + 1)) : $urandom_range(0, spread / 4 + 1);
      if (z > 8388607) z = 8388607;
    end
  endtask

  task automatic load_edges(input int spread);
    logic [53:0] ev;
    ev = 0;
    for (int k = 0; k < MAX_BINS; k++) begin
      send_q.push_back(mk(KIND_EDGE, $urandom(), $urandom(), $urandom(),
                          $urandom_range(0, 1), k[4:0], ev));
      ev += $urandom_range(1, spread * spread / 8 + 1);
    end
  endtask

  initial begin
    rst_n = 0; cfg_we = 0; cfg_index = 0; cfg_wdata = 0;
    pt_total = 0; q_idx = 0;
    for (int k = 0; k < MAX_BINS; k++) begin
      hist[k] = 0; edge_sq[k] = 0;
    end
    r_bins = 32; r_same = 0; r_zlim = '1; r_min = 0; r_max = M54;
    r_ox = 0; r_oy = 0; r_oz = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Flush right after reset: every bin reads zero, last flag on bin 31.
    for (int k = 0; k < 32; k++) fixed_tab.push_back('{k[4:0], 48'd0, k == 31});
    send_q.push_back(mk(KIND_FLUSH, 0, 0, 0, 0, 0, 0));
    drain();
    if (fixed_tab.size() != 0) begin
      report_mismatch("fixed rows not seen", fixed_tab.size(), 0);
      fixed_tab.delete();
    end

    // Edge extremes, a two-point set at coordinate extremes, queries, flush.
    dir_tab.push_back(mk(KIND_EDGE, 0, 0, 0, 0, 5'd0, 54'd0));
    dir_tab.push_back(mk(KIND_EDGE, 0, 0, 0, 0, 5'd1, M54));
    dir_tab.push_back(mk(KIND_EDGE, 0, 0, 0, 0, 5'd31, 54'd100));
    for (int k = 2; k < 31; k++)
      dir_tab.push_back(mk(KIND_EDGE, 0, 0, 0, 0, k[4:0], 54'(k * 1000)));
    dir_tab.push_back(mk(KIND_POINT, 24'h800000, 24'h7fffff, 24'h800000, 1, 0, 0));
    dir_tab.push_back(mk(KIND_POINT, 24'h7fffff, 24'h800000, 24'h7fffff, 0, 0, 0));
    dir_tab.push_back(mk(KIND_QUERY, 24'h7fffff, 24'h7fffff, 24'h7fffff, 0, 0, 0));
    dir_tab.push_back(mk(KIND_QUERY, 24'h800000, 24'h800000, 24'h800000, 0, 0, 0));
    dir_tab.push_back(mk(KIND_QUERY, 24'h0, 24'h0, 24'h0, 0, 0, 0));
    dir_tab.push_back(mk(KIND_FLUSH, 0, 0, 0, 0, 0, 0));
    foreach (dir_tab[i]) send_q.push_back(dir_tab[i]);
    edges_loaded = 1;
    drain();

    // Extreme registers: one bin, zero z window, extreme offsets, same-set mode.
    write_reg(CFG_NUM_BINS, 54'd0);
    write_reg(CFG_Z_LIMIT, 54'd0);
    write_reg(CFG_OFFSET_X, 54'h7fffff);
    write_reg(CFG_OFFSET_Y, 54'h800000);
    write_reg(CFG_OFFSET_Z, 54'h7fffff);
    write_reg(CFG_MIN_DIST, M54);
    write_reg(CFG_MAX_DIST, 54'd0);
    write_reg(CFG_SAME_SET, 54'd1);
    send_q.push_back(mk(KIND_QUERY, 1, 2, 3, 0, 0, 0));
    send_q.push_back(mk(KIND_FLUSH, 0, 0, 0, 0, 0, 0));
    drain();

    // Random phases under several settings; one of them forces a long hold.
    for (int ph = 0; ph < 6; ph++) begin
      int spread, npts;
      bit wild;
      wild = (ph == 3);
      spread = (ph % 2) ? 2000 : 60;
      npts = $urandom_range(4, 20);
      write_reg(CFG_NUM_BINS, (ph == 2) ? 54'd63 : $urandom_range(1, 40));
      write_reg(CFG_SAME_SET, ph % 3 == 1);
      write_reg(CFG_Z_LIMIT, wild ? 54'h1ffffff : $urandom_range(0, spread));
      write_reg(CFG_MIN_DIST, $urandom_range(0, 3) == 0 ? $urandom_range(0, spread) : 0);
      write_reg(CFG_MAX_DIST, (ph == 5) ? rnd54() : ($urandom_range(0, 1) ? M54
                              : 54'(spread * spread * 3)));
      write_reg(CFG_OFFSET_X, wild ? rnd54() : $urandom_range(0, 20) - 10);
      write_reg(CFG_OFFSET_Y, wild ? rnd54() : $urandom_range(0, 20) - 10);
      write_reg(CFG_OFFSET_Z, wild ? rnd54() : $urandom_range(0, 20) - 10);
      load_edges(spread);
      load_set(npts, spread, wild);
      if (ph == 4) begin
        // Hold the receiver off while an early flush backs the core up
        long_hold = 1;
        send_q.push_back(mk(KIND_FLUSH, 0, 0, 0, 0, 0, 0));
      end
      for (int q = 0; q < 12; q++) begin
        case ($urandom_range(0, 9))
          0: send_q.push_back(mk(KIND_FLUSH, $urandom(), $urandom(), $urandom(),
                                 $urandom_range(0, 1), $urandom(), rnd54()));
          1: send_q.push_back(mk(KIND_EDGE, 0, 0, 0, 0, $urandom(),
                                 54'($urandom_range(0, spread * spread))));
          default: send_q.push_back(mk(KIND_QUERY,
                     wild ? $urandom() : $urandom_range(0, 2 * spread) - spread,
                     wild ? $urandom() : $urandom_range(0, 2 * spread) - spread,
                     wild ? $urandom() : $urandom_range(0, 2 * spread) - spread,
                     $urandom_range(0, 1), $urandom(), rnd54()));
        endcase
      end
      send_q.push_back(mk(KIND_FLUSH, 0, 0, 0, 0, 0, 0));
      drain();
    end

    if (errors == 0 && pending_bins.size() == 0) begin
      $display("PASS radial_pair_count_histogram_core");
    end else begin
      $display("FAIL radial_pair_count_histogram_core");
    end
    $finish;
  end

endmodule
